### sv/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion helpers for the RTL.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset
`define ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// Next-cycle implication, disabled during reset
`define ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

### sv/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, command codes, types and popcount for the page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    localparam int PAGE_UNITS = 1024;
    localparam int WORD_BITS  = 32;
    localparam int NWORDS     = PAGE_UNITS / WORD_BITS;
    localparam int UNIT_W     = $clog2(PAGE_UNITS);
    localparam int WADDR_W    = $clog2(NWORDS);
    localparam int BIT_W      = $clog2(WORD_BITS);
    localparam int CNT_W      = UNIT_W + 1;

    // Command codes
    localparam logic [2:0] CMD_ALLOC = 3'd0;
    localparam logic [2:0] CMD_MARK  = 3'd1;
    localparam logic [2:0] CMD_TEST  = 3'd2;
    localparam logic [2:0] CMD_BEGIN = 3'd3;
    localparam logic [2:0] CMD_END   = 3'd4;
    localparam logic [2:0] CMD_READ  = 3'd5;

    // Result of scanning one bitmap word for a free run
    typedef struct packed {
        logic             hit;
        logic [BIT_W-1:0] pos;
        logic [CNT_W-1:0] carry;
    } t_scan_res;

    // SWAR popcount of one word
    function automatic logic [5:0] pop32(input logic [31:0] w);
        logic [31:0] b;
        begin
            b = w - ((w >> 1) & 32'h55555555);
            b = (b & 32'h33333333) + ((b >> 2) & 32'h33333333);
            b = (b + (b >> 4)) & 32'h0f0f0f0f;
            b = b * 32'h01010101;
            return b[29:24];
        end
    endfunction

endpackage

### sv/bpa_ram.sv
// ----------------------------------------------------------------------------
// bpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module bpa_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

### sv/bpa_scan.sv
// ----------------------------------------------------------------------------
// bpa_scan
// Finds the first bit of a word at which a free run reaches the needed length.
// ----------------------------------------------------------------------------
module bpa_scan
    import bpa_pkg::*;
(
    input  logic [WORD_BITS-1:0] i_word,
    input  logic [BIT_W-1:0]     i_start_off,
    input  logic                 i_excl_top,
    input  logic [CNT_W-1:0]     i_carry,
    input  logic [CNT_W-1:0]     i_need,
    output t_scan_res            o_res
);

    logic [WORD_BITS-1:0] blk;
    logic [CNT_W-1:0]     run;
    logic                 seen;
    logic [BIT_W-1:0]     lastset;

    // Per bit: clear run length ending there, first hit wins
    always_comb begin
        blk = i_word | ((WORD_BITS'(1) << i_start_off) - WORD_BITS'(1));
        if (i_excl_top) begin
            blk[WORD_BITS-1] = 1'b1;
        end
        o_res   = '0;
        run     = '0;
        seen    = 1'b0;
        lastset = '0;
        for (int j = 0; j < WORD_BITS; j++) begin
            seen    = 1'b0;
            lastset = '0;
            for (int k = 0; k < WORD_BITS; k++) begin
                if (k <= j && blk[k]) begin
                    seen    = 1'b1;
                    lastset = BIT_W'(k);
                end
            end
            if (seen) begin
                run = CNT_W'(j) - {{(CNT_W-BIT_W){1'b0}}, lastset};
            end else begin
                run = i_carry + CNT_W'(j + 1);
            end
            if (!blk[j] && run >= i_need && !o_res.hit) begin
                o_res.hit = 1'b1;
                o_res.pos = BIT_W'(j);
            end
        end
        o_res.carry = run;
    end

endmodule

### sv/bitmap_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// bitmap_page_allocator_unit: one item at a time; an unknown command or an empty range
// goes straight to the result; alloc scans one word/cycle from the cursor, then marks one
// word/cycle. begin/end_cycle sweep all 32 words; mark/test walk the words of the
// range. Next transaction is taken the cycle after the result is registered.
// Sync active-low reset: bitmaps read as zero, cursor 0, threshold 768.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bitmap_page_allocator_unit
    import bpa_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [10:0] i_cfg_wdata,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // cmd[2:0], unit_index[12:3], run_length[22:13], word_index[27:23]
    input  logic [31:0] s_axis_tdata,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // ok[0], header_index[10:1], any_marked[11], inuse_count[22:12],
    // grow_request[23], dead_word[55:24]
    output logic [63:0] m_axis_tdata
);

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_SCAN  = 4'd1;
    localparam logic [3:0] ST_AMARK = 4'd2;
    localparam logic [3:0] ST_RANGE = 4'd3;
    localparam logic [3:0] ST_COPY  = 4'd4;
    localparam logic [3:0] ST_SWEEP = 4'd5;
    localparam logic [3:0] ST_READ  = 4'd6;
    localparam logic [3:0] ST_DONE  = 4'd7;

    logic [3:0]           r_state;
    logic [2:0]           r_cmd;
    logic [UNIT_W-1:0]    r_lo, r_hi, r_cursor;
    logic [CNT_W-1:0]     r_need, r_carry, r_thr, r_total;
    logic [WADDR_W-1:0]   r_addr, r_last, r_rd_addr;
    logic                 r_issue, r_rd_vld, r_first;
    logic [NWORDS-1:0]    r_mark_vld, r_shad_vld;
    logic                 r_mvq, r_svq;
    logic                 r_ok, r_anym, r_grow;
    logic [UNIT_W-1:0]    r_hdr;
    logic [CNT_W-1:0]     r_cnt;
    logic [WORD_BITS-1:0] r_dead;
    logic                 r_o_vld;
    logic [63:0]          r_o_data;

    logic [WORD_BITS-1:0] mark_rdata, shad_rdata, mark_eff, shad_eff;
    logic [WORD_BITS-1:0] rmask, mark_wdata, shad_wdata;
    logic                 mark_we, shad_we;
    logic [BIT_W-1:0]     lo_off, hi_off;
    logic [CNT_W-1:0]     sum_end, pop_sum;
    logic [UNIT_W-1:0]    hit_i, hit_p;
    t_scan_res            scan;

    logic [2:0]        in_cmd;
    logic [UNIT_W-1:0] in_uidx, in_len;
    logic [4:0]        in_widx;
    logic              in_acc;

    assign in_cmd  = s_axis_tdata[2:0];
    assign in_uidx = s_axis_tdata[12:3];
    assign in_len  = s_axis_tdata[22:13];
    assign in_widx = s_axis_tdata[27:23];
    assign s_axis_tready = (r_state == ST_IDLE);
    assign in_acc  = s_axis_tvalid && s_axis_tready;
    assign m_axis_tvalid = r_o_vld;
    assign m_axis_tdata  = r_o_data;

    // Memories
    bpa_ram #(.WIDTH(WORD_BITS), .DEPTH(NWORDS)) u_mark_ram (
        .i_clk(i_clk), .i_we(mark_we), .i_waddr(r_rd_addr), .i_wdata(mark_wdata),
        .i_raddr(r_addr), .o_rdata(mark_rdata)
    );

    bpa_ram #(.WIDTH(WORD_BITS), .DEPTH(NWORDS)) u_shad_ram (
        .i_clk(i_clk), .i_we(shad_we), .i_waddr(r_rd_addr), .i_wdata(shad_wdata),
        .i_raddr(r_addr), .o_rdata(shad_rdata)
    );

    // Free-run search over the word just read
    bpa_scan u_scan (
        .i_word(mark_eff),
        .i_start_off(r_first ? r_cursor[BIT_W-1:0] : '0),
        .i_excl_top(r_rd_addr == WADDR_W'(NWORDS - 1)),
        .i_carry(r_carry),
        .i_need(r_need),
        .o_res(scan)
    );

    // Read data, range mask, write data
    always_comb begin
        mark_eff = r_mvq ? mark_rdata : '0;
        shad_eff = r_svq ? shad_rdata : '0;
        lo_off = (r_rd_addr == r_lo[UNIT_W-1:BIT_W]) ? r_lo[BIT_W-1:0] : '0;
        hi_off = (r_rd_addr == r_hi[UNIT_W-1:BIT_W]) ? r_hi[BIT_W-1:0] : '1;
        rmask = ({WORD_BITS{1'b1}} << lo_off) & ({WORD_BITS{1'b1}} >> (~hi_off));
        mark_we = r_rd_vld &&
                  (r_state == ST_AMARK || (r_state == ST_RANGE && r_cmd == CMD_MARK));
        mark_wdata = mark_eff | rmask;
        shad_we = r_rd_vld && (r_state == ST_COPY || r_state == ST_SWEEP);
        shad_wdata = (r_state == ST_COPY) ? mark_eff : (shad_eff & ~mark_eff);
        pop_sum = r_total + {{(CNT_W-6){1'b0}}, pop32(mark_eff)};
        hit_i = {r_rd_addr, scan.pos};
        hit_p = UNIT_W'({1'b0, hit_i} + CNT_W'(1) - r_need);
        sum_end = {1'b0, in_uidx} + {1'b0, in_len};
        if (sum_end > CNT_W'(PAGE_UNITS)) begin
            sum_end = CNT_W'(PAGE_UNITS);
        end
    end

    // Control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= ST_IDLE;
            r_issue    <= 1'b0;
            r_rd_vld   <= 1'b0;
            r_mark_vld <= '0;
            r_shad_vld <= '0;
            r_cursor   <= '0;
            r_thr      <= CNT_W'(768);
            r_o_vld    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_thr <= i_cfg_wdata;
            end
            // word walk: one read issued per cycle
            r_mvq <= r_mark_vld[r_addr];
            r_svq <= r_shad_vld[r_addr];
            if (r_issue) begin
                r_rd_vld  <= 1'b1;
                r_rd_addr <= r_addr;
                if (r_addr == r_last) begin
                    r_issue <= 1'b0;
                end else begin
                    r_addr <= r_addr + 1'b1;
                end
            end else begin
                r_rd_vld <= 1'b0;
            end
            if (mark_we) begin
                r_mark_vld[r_rd_addr] <= 1'b1;
            end
            if (shad_we) begin
                r_shad_vld[r_rd_addr] <= 1'b1;
            end
            if (m_axis_tvalid && m_axis_tready) begin
                r_o_vld <= 1'b0;
            end

            unique case (r_state)
                ST_IDLE: begin
                    if (in_acc) begin
                        r_cmd   <= in_cmd;
                        r_ok    <= 1'b1;
                        r_hdr   <= '0;
                        r_anym  <= 1'b0;
                        r_cnt   <= '0;
                        r_grow  <= 1'b0;
                        r_dead  <= '0;
                        r_total <= '0;
                        r_addr  <= '0;
                        r_last  <= WADDR_W'(NWORDS - 1);
                        r_issue <= 1'b1;
                        case (in_cmd)
                            CMD_ALLOC: begin
                                r_ok    <= 1'b0;
                                r_need  <= {1'b0, in_len} + CNT_W'(1);
                                r_addr  <= r_cursor[UNIT_W-1:BIT_W];
                                r_first <= 1'b1;
                                r_carry <= '0;
                                r_state <= ST_SCAN;
                            end
                            CMD_MARK, CMD_TEST: begin
                                r_lo   <= in_uidx;
                                r_hi   <= UNIT_W'(sum_end - CNT_W'(1));
                                r_addr <= in_uidx[UNIT_W-1:BIT_W];
                                r_last <= WADDR_W'((sum_end - CNT_W'(1)) >> BIT_W);
                                if (in_len == '0) begin
                                    r_issue <= 1'b0;
                                    r_state <= ST_DONE;
                                end else begin
                                    r_state <= ST_RANGE;
                                end
                            end
                            CMD_BEGIN: r_state <= ST_COPY;
                            CMD_END:   r_state <= ST_SWEEP;
                            CMD_READ: begin
                                r_addr  <= in_widx;
                                r_last  <= in_widx;
                                r_state <= ST_READ;
                            end
                            default: begin
                                r_issue <= 1'b0;
                                r_state <= ST_DONE;
                            end
                        endcase
                    end
                end
                ST_SCAN: begin
                    if (r_rd_vld) begin
                        r_first <= 1'b0;
                        r_carry <= scan.carry;
                        if (scan.hit) begin
                            r_ok     <= 1'b1;
                            r_hdr    <= hit_p;
                            r_cursor <= hit_i + 1'b1;
                            r_lo     <= hit_p;
                            r_hi     <= hit_i;
                            r_addr   <= hit_p[UNIT_W-1:BIT_W];
                            r_last   <= r_rd_addr;
                            r_issue  <= 1'b1;
                            r_rd_vld <= 1'b0;
                            r_state  <= ST_AMARK;
                        end else if (r_rd_addr == WADDR_W'(NWORDS - 1)) begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_AMARK: begin
                    if (r_rd_vld && r_rd_addr == r_last) begin
                        r_state <= ST_DONE;
                    end
                end
                ST_RANGE: begin
                    if (r_rd_vld) begin
                        if (r_cmd == CMD_TEST && (mark_eff & rmask) != '0) begin
                            r_anym <= 1'b1;
                        end
                        if (r_rd_addr == r_last) begin
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_COPY: begin
                    if (r_rd_vld && r_rd_addr == r_last) begin
                        r_mark_vld <= '0;
                        r_cursor   <= '0;
                        r_state    <= ST_DONE;
                    end
                end
                ST_SWEEP: begin
                    if (r_rd_vld) begin
                        r_total <= pop_sum;
                        if (r_rd_addr == r_last) begin
                            r_cnt   <= pop_sum;
                            r_grow  <= (pop_sum >= r_thr);
                            r_state <= ST_DONE;
                        end
                    end
                end
                ST_READ: begin
                    if (r_rd_vld) begin
                        r_dead  <= shad_eff;
                        r_state <= ST_DONE;
                    end
                end
                ST_DONE: begin
                    if (!r_o_vld || m_axis_tready) begin
                        r_o_vld  <= 1'b1;
                        r_o_data <= {8'd0, r_dead, r_grow, r_cnt, r_anym, r_hdr, r_ok};
                        r_state  <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // Checks
    `ASSERT_IMP(a_no_write_idle, i_clk, i_rst_n, r_state == ST_IDLE, !mark_we && !shad_we)
    `ASSERT_NXT(a_busy_after_acc, i_clk, i_rst_n, in_acc, r_state != ST_IDLE)
    `ASSERT_IMP(a_fail_hdr_zero, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tdata[0], m_axis_tdata[10:1] == 10'd0)

endmodule

### test/tb_bitmap_page_allocator_unit.sv
// ----------------------------------------------------------------------------
// tb_bitmap_page_allocator_unit
// Self-checking bench for the bitmap page allocator. A behavioral copy of the
// page bitmap, shadow and cursor predicts every result. Directed rows come
// first, then random heap cycles, with bursty input and a stalling receiver.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module tb_bitmap_page_allocator_unit;
    import bpa_pkg::*;

    localparam int WAIT_CYC = 80;

    typedef struct packed {
        logic        ok;
        logic [9:0]  hdr;
        logic        anym;
        logic [10:0] cnt;
        logic        grow;
        logic [31:0] dead;
    } t_answer;

    typedef struct {
        logic [2:0] cmd;
        logic [9:0] uidx;
        logic [9:0] len;
        logic [4:0] widx;
        logic       has_exp;
        t_answer    exp;
    } t_row;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        i_cfg_we = 1'b0;
    logic [10:0] i_cfg_wdata = '0;
    logic        s_axis_tvalid = 1'b0;
    logic        s_axis_tready;
    logic [31:0] s_axis_tdata = '0;
    logic        m_axis_tvalid;
    logic        m_axis_tready = 1'b0;
    logic [63:0] m_axis_tdata;

    bitmap_page_allocator_unit u_top (.*);

    always #6 i_clk = ~i_clk;

    // Predictor state
    logic [PAGE_UNITS-1:0] heap_map, dead_map;
    int unsigned           next_fit;
    logic [10:0]           grow_level;
    t_answer               answer_q[$];
    int                    errors = 0;
    int                    n_sent = 0, n_got = 0, n_alloc_ok = 0, n_alloc_fail = 0;
    bit                    long_hold = 1'b0;

    function automatic t_answer predict(logic [2:0] cmd, logic [9:0] uidx,
                                        logic [9:0] len, logic [4:0] widx);
        t_answer     r;
        int unsigned run, need, lim;
        r = '0;
        r.ok = 1'b1;
        case (cmd)
            CMD_ALLOC: begin
                r.ok = 1'b0;
                need = len + 1;
                run = 0;
                for (int unsigned i = next_fit; i + 1 < PAGE_UNITS; i++) begin
                    run = heap_map[i] ? 0 : run + 1;
                    if (run == need) begin
                        for (int unsigned k = i + 1 - need; k <= i; k++) heap_map[k] = 1'b1;
                        r.hdr = 10'(i + 1 - need);
                        r.ok = 1'b1;
                        next_fit = i + 1;
                        break;
                    end
                end
                if (r.ok) n_alloc_ok++;
                else n_alloc_fail++;
            end
            CMD_MARK, CMD_TEST: begin
                lim = uidx + len;
                if (lim > PAGE_UNITS) lim = PAGE_UNITS;
                for (int unsigned i = uidx; i < lim; i++) begin
                    if (cmd == CMD_MARK) heap_map[i] = 1'b1;
                    else if (heap_map[i]) r.anym = 1'b1;
                end
            end
            CMD_BEGIN: begin
                dead_map = heap_map;
                heap_map = '0;
                next_fit = 0;
            end
            CMD_END: begin
                dead_map = dead_map & ~heap_map;
                r.cnt = 11'($countones(heap_map));
                r.grow = (r.cnt >= grow_level);
            end
            CMD_READ: r.dead = dead_map[widx*32 +: 32];
            default: ;
        endcase
        return r;
    endfunction

    // Drive one transaction at the falling edge and wait for acceptance
    task automatic send_item(logic [2:0] cmd, logic [9:0] uidx, logic [9:0] len,
                             logic [4:0] widx, bit has_exp, t_answer exp);
        t_answer p;
        p = predict(cmd, uidx, len, widx);
        if (has_exp && p !== exp) begin
            $display("%0t table row mismatch: expected %h actual %h", $time, exp, p);
            errors++;
        end
        answer_q.push_back(p);
        s_axis_tdata <= {4'd0, widx, len, uidx, cmd};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        n_sent++;
        @(negedge i_clk);
    endtask

    task automatic idle_cycles(int n);
        s_axis_tvalid <= 1'b0;
        repeat (n) @(negedge i_clk);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (answer_q.size() != 0) @(negedge i_clk);
        repeat (WAIT_CYC) @(negedge i_clk);
    endtask

    task automatic write_threshold(logic [10:0] v);
        i_cfg_wdata <= v;
        i_cfg_we <= 1'b1;
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        grow_level = v;
    endtask

    task automatic random_item();
        int       sel;
        logic [9:0] len;
        sel = $urandom_range(0, 99);
        len = ($urandom_range(0, 9) == 0) ? 10'($urandom) : 10'($urandom_range(0, 40));
        if (sel < 45)      send_item(CMD_ALLOC, 10'($urandom), len, 5'($urandom), 0, '0);
        else if (sel < 60) send_item(CMD_MARK, 10'($urandom), len, 5'($urandom), 0, '0);
        else if (sel < 75) send_item(CMD_TEST, 10'($urandom), len, 5'($urandom), 0, '0);
        else if (sel < 80) send_item(CMD_BEGIN, 10'($urandom), 10'($urandom),
                                     5'($urandom), 0, '0);
        else if (sel < 86) send_item(CMD_END, 10'($urandom), 10'($urandom),
                                     5'($urandom), 0, '0);
        else if (sel < 97) send_item(CMD_READ, 10'($urandom), 10'($urandom),
                                     5'($urandom), 0, '0);
        else               send_item(3'($urandom_range(6, 7)), 10'($urandom),
                                     10'($urandom), 5'($urandom), 0, '0);
    endtask

    // Directed rows; expectation typed in where obvious
    t_row dir_tab[] = '{
        '{CMD_END,   10'd0,    10'd0,    5'd0,  1, '{1'b1, 10'd0, 1'b0, 11'd0, 1'b0, 32'd0}},
        '{CMD_READ,  10'd0,    10'd0,    5'd31, 1, '{1'b1, 10'd0, 1'b0, 11'd0, 1'b0, 32'd0}},
        '{CMD_TEST,  10'd0,    10'd1023, 5'd0,  1, '{1'b1, 10'd0, 1'b0, 11'd0, 1'b0, 32'd0}},
        '{CMD_ALLOC, 10'd0,    10'd0,    5'd0,  1, '{1'b1, 10'd0, 1'b0, 11'd0, 1'b0, 32'd0}},
        '{CMD_ALLOC, 10'd0,    10'd1023, 5'd0,  1, '{1'b0, 10'd0, 1'b0, 11'd0, 1'b0, 32'd0}},
        '{CMD_ALLOC, 10'd0,    10'd5,    5'd0,  1, '{1'b1, 10'd1, 1'b0, 11'd0, 1'b0, 32'd0}},
        '{CMD_MARK,  10'd0,    10'd0,    5'd0,  0, '0},
        '{CMD_TEST,  10'd3,    10'd0,    5'd0,  1, '{1'b1, 10'd0, 1'b0, 11'd0, 1'b0, 32'd0}},
        '{CMD_MARK,  10'd1023, 10'd1023, 5'd0,  0, '0},
        '{CMD_TEST,  10'd1000, 10'd1023, 5'd0,  0, '0},
        '{CMD_MARK,  10'd100,  10'd64,   5'd0,  0, '0},
        '{CMD_ALLOC, 10'd0,    10'd200,  5'd0,  0, '0},
        '{CMD_ALLOC, 10'd0,    10'd1000, 5'd0,  0, '0},
        '{CMD_END,   10'd0,    10'd0,    5'd0,  0, '0},
        '{CMD_BEGIN, 10'd0,    10'd0,    5'd0,  0, '0},
        '{CMD_MARK,  10'd96,   10'd40,   5'd0,  0, '0},
        '{CMD_END,   10'd0,    10'd0,    5'd0,  0, '0},
        '{CMD_READ,  10'd0,    10'd0,    5'd3,  0, '0},
        '{CMD_READ,  10'd0,    10'd0,    5'd31, 0, '0},
        '{3'd6,      10'd1023, 10'd1023, 5'd31, 1, '{1'b1, 10'd0, 1'b0, 11'd0, 1'b0, 32'd0}},
        '{3'd7,      10'd0,    10'd0,    5'd0,  1, '{1'b1, 10'd0, 1'b0, 11'd0, 1'b0, 32'd0}},
        '{CMD_ALLOC, 10'd0,    10'd1021, 5'd0,  0, '0},
        '{CMD_TEST,  10'd0,    10'd1023, 5'd0,  0, '0},
        '{CMD_END,   10'd0,    10'd0,    5'd0,  0, '0}
    };

    // Receiver: stall pattern plus one long hold-off
    initial begin
        int hold;
        forever begin
            @(negedge i_clk);
            if (long_hold) begin
                m_axis_tready <= 1'b0;
                for (hold = 0; hold < 400; hold++) @(negedge i_clk);
                long_hold = 1'b0;
            end
            m_axis_tready <= ($urandom_range(0, 3) != 0);
        end
    end

    // Result checker
    always @(posedge i_clk) begin
        t_answer got, exp;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            got.ok   = m_axis_tdata[0];
            got.hdr  = m_axis_tdata[10:1];
            got.anym = m_axis_tdata[11];
            got.cnt  = m_axis_tdata[22:12];
            got.grow = m_axis_tdata[23];
            got.dead = m_axis_tdata[55:24];
            n_got++;
            if (answer_q.size() == 0) begin
                $display("%0t unexpected result: expected none actual %h", $time, got);
                errors++;
            end else begin
                exp = answer_q.pop_front();
                if (got.ok !== exp.ok || got.hdr !== exp.hdr || got.anym !== exp.anym ||
                    got.cnt !== exp.cnt || got.grow !== exp.grow || got.dead !== exp.dead) begin
                    $display("%0t mismatch: expected ok=%b hdr=%0d any=%b cnt=%0d grow=%b dead=%h",
                             $time, exp.ok, exp.hdr, exp.anym, exp.cnt, exp.grow, exp.dead);
                    $display("%0t            actual ok=%b hdr=%0d any=%b cnt=%0d grow=%b dead=%h",
                             $time, got.ok, got.hdr, got.anym, got.cnt, got.grow, got.dead);
                    errors++;
                end
            end
        end
    end

    // Run limit
    initial begin
        #(12 * 3_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    // Stimulus
    initial begin
        logic [10:0] thr_set[5];
        thr_set = '{11'd0, 11'd1024, 11'd2047, 11'd40, 11'd300};
        heap_map = '0;
        dead_map = '0;
        next_fit = 0;
        grow_level = 11'd768;
        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (dir_tab[r])
            send_item(dir_tab[r].cmd, dir_tab[r].uidx, dir_tab[r].len, dir_tab[r].widx,
                      dir_tab[r].has_exp, dir_tab[r].exp);
        drain();

        // Random phases, each under a different threshold
        foreach (thr_set[p]) begin
            write_threshold(thr_set[p]);
            if (p == 1) long_hold = 1'b1;
            for (int n = 0; n < 325; ) begin
                int burst;
                burst = $urandom_range(1, 20);
                for (int b = 0; b < burst && n < 325; b++, n++) random_item();
                if ($urandom_range(0, 2) == 0) idle_cycles($urandom_range(1, 40));
            end
            drain();
        end

        $display("Covered %0d commands over 5 threshold settings, %0d results checked.",
                 n_sent, n_got);
        $display("Allocations: %0d placed, %0d refused for lack of space.",
                 n_alloc_ok, n_alloc_fail);
        if (errors == 0) $display("RESULT: OK");
        else $display("RESULT: ERROR");
        $finish;
    end

endmodule
